### hdl/sector_buffer_cache_policy_defines.svh
// Assertion helpers for the sector buffer cache.
`ifndef SECTOR_BUFFER_CACHE_POLICY_DEFINES_SVH
`define SECTOR_BUFFER_CACHE_POLICY_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication outside reset.
`define SBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/sbc_pkg.sv
package sbc_pkg;

    localparam int SLOTS       = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int SIDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [SIDX_W-1:0]      sidx_t;

    localparam cnt_t CNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_GET     = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_FLUSH   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_WRITEBACK = 2'd0,
        RES_FETCH     = 2'd1,
        RES_ZERO_FILL = 2'd2,
        RES_STATUS    = 2'd3
    } res_kind_t;

    typedef enum logic [2:0] {
        STS_HIT      = 3'd0,
        STS_FILLED   = 3'd1,
        STS_BUSY     = 3'd2,
        STS_NO_FREE  = 3'd3,
        STS_OOB      = 3'd4,
        STS_RELEASED = 3'd5,
        STS_NOT_HELD = 3'd6,
        STS_FLUSHED  = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HIT_SCAN,
        ST_HIT_ACT,
        ST_AGE_SCAN,
        ST_MISS_WB,
        ST_MISS_FILL,
        ST_MISS_DONE,
        ST_RELEASE,
        ST_FLUSH_SCAN,
        ST_FLUSH_END
    } state_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] sector;
        cnt_t        age;
        cnt_t        use_cur;
        cnt_t        best_age;
        cnt_t        best_use;
    } unit_in_t;

    typedef struct packed {
        logic tag_eq;
        cnt_t age_inc;
        logic better;
    } unit_out_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? v : v + cnt_t'(1);
    endfunction

    function automatic logic in_bounds(input logic [31:0] s, input logic [31:0] total);
        return (total == 32'd0) || (s < total);
    endfunction

endpackage

### hdl/sbc_unit.sv
module sbc_unit
    import sbc_pkg::*;
(
    input  unit_in_t  u_in,
    output unit_out_t u_out
);

    cnt_t age_new;

    always_comb
    begin
        age_new        = sat_inc(u_in.age);
        u_out.tag_eq   = (u_in.tag == u_in.sector);
        u_out.age_inc  = age_new;
        u_out.better   = (age_new > u_in.best_age) ||
                         ((age_new == u_in.best_age) && (u_in.use_cur > u_in.best_use));
    end

endmodule

### hdl/sector_buffer_cache_policy.sv
// Sector buffer cache policy. One request at a time: start is taken when busy
// is low. A get walks the descriptors one slot per cycle through a single
// shared compare/increment unit: first the tag lookup, then on a miss an aging
// pass over all slots, then control states that issue the writeback, fill and
// status results. A flush walks every slot once, a release checks one slot.
// Results come out at most one per cycle on res_valid, with last
// on the final status; the receiver cannot stall, so take every strobe.
// The size register total_reg is written through cfg_valid/cfg_ready while idle.
`include "sector_buffer_cache_policy_defines.svh"

module sector_buffer_cache_policy
    import sbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] sector,
    input  logic [1:0]  mode_bits,
    input  logic        no_fill,
    input  logic [5:0]  slot,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        res_valid,
    output logic [1:0]  res_kind,
    output logic [5:0]  res_slot,
    output logic [31:0] res_sector,
    output logic [2:0]  status,
    output logic        last
);

    state_t state_reg, state_next;

    logic [31:0] total_reg;
    logic [31:0] tag_reg   [SLOTS];
    logic [31:0] tag_next  [SLOTS];
    logic        valid_reg [SLOTS];
    logic        valid_next[SLOTS];
    logic [1:0]  mode_reg  [SLOTS];
    logic [1:0]  mode_next [SLOTS];
    logic        dirty_reg [SLOTS];
    logic        dirty_next[SLOTS];
    cnt_t        hcnt_reg  [SLOTS];
    cnt_t        hcnt_next [SLOTS];
    cnt_t        age_reg   [SLOTS];
    cnt_t        age_next  [SLOTS];
    cnt_t        ucnt_reg  [SLOTS];
    cnt_t        ucnt_next [SLOTS];

    logic [31:0] sec_reg,  sec_next;
    logic [1:0]  mb_reg,   mb_next;
    logic        nf_reg,   nf_next;
    logic [5:0]  rslot_reg, rslot_next;
    sidx_t       idx_reg,  idx_next;
    logic        found_reg, found_next;
    sidx_t       lru_reg,  lru_next;
    cnt_t        bage_reg, bage_next;
    cnt_t        buse_reg, buse_next;

    logic        ov_reg, ov_next;
    logic [1:0]  ok_reg, ok_next;
    logic [5:0]  os_reg, os_next;
    logic [31:0] osec_reg, osec_next;
    logic [2:0]  ost_reg, ost_next;
    logic        olast_reg, olast_next;

    unit_in_t  u_in;
    unit_out_t u_out;
    logic      idx_end;
    logic      plain_read;

    sbc_unit u_unit (
        .u_in  (u_in),
        .u_out (u_out)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign res_valid = ov_reg;
    assign res_kind  = ok_reg;
    assign res_slot  = os_reg;
    assign res_sector = osec_reg;
    assign status    = ost_reg;
    assign last      = olast_reg;

    assign idx_end    = (idx_reg == sidx_t'(SLOTS - 1));
    assign plain_read = (mb_reg == 2'd1) && !nf_reg;

    always_comb
    begin
        u_in.tag      = tag_reg[idx_reg];
        u_in.sector   = sec_reg;
        u_in.age      = age_reg[idx_reg];
        u_in.use_cur  = ucnt_reg[idx_reg];
        u_in.best_age = bage_reg;
        u_in.best_use = buse_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            ov_reg    <= 1'b0;
            found_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                tag_reg[i]   <= '0;
                valid_reg[i] <= 1'b0;
                mode_reg[i]  <= '0;
                dirty_reg[i] <= 1'b0;
                hcnt_reg[i]  <= '0;
                age_reg[i]   <= '0;
                ucnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            found_reg <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                total_reg <= cfg_data;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                tag_reg[i]   <= tag_next[i];
                valid_reg[i] <= valid_next[i];
                mode_reg[i]  <= mode_next[i];
                dirty_reg[i] <= dirty_next[i];
                hcnt_reg[i]  <= hcnt_next[i];
                age_reg[i]   <= age_next[i];
                ucnt_reg[i]  <= ucnt_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg   <= sec_next;
        mb_reg    <= mb_next;
        nf_reg    <= nf_next;
        rslot_reg <= rslot_next;
        idx_reg   <= idx_next;
        lru_reg   <= lru_next;
        bage_reg  <= bage_next;
        buse_reg  <= buse_next;
        ok_reg    <= ok_next;
        os_reg    <= os_next;
        osec_reg  <= osec_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next = state_reg;
        tag_next   = tag_reg;
        valid_next = valid_reg;
        mode_next  = mode_reg;
        dirty_next = dirty_reg;
        hcnt_next  = hcnt_reg;
        age_next   = age_reg;
        ucnt_next  = ucnt_reg;
        sec_next   = sec_reg;
        mb_next    = mb_reg;
        nf_next    = nf_reg;
        rslot_next = rslot_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        lru_next   = lru_reg;
        bage_next  = bage_reg;
        buse_next  = buse_reg;
        ov_next    = 1'b0;
        ok_next    = RES_STATUS;
        os_next    = '0;
        osec_next  = '0;
        ost_next   = STS_HIT;
        olast_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sec_next   = sector;
                    mb_next    = mode_bits;
                    nf_next    = no_fill;
                    rslot_next = slot;
                    idx_next   = '0;
                    found_next = 1'b0;
                    unique case (kind_t'(kind))
                        KIND_GET:     state_next = ST_HIT_SCAN;
                        KIND_RELEASE:
                        begin
                            idx_next   = slot[SIDX_W-1:0];
                            state_next = ST_RELEASE;
                        end
                        KIND_FLUSH:   state_next = ST_FLUSH_SCAN;
                        KIND_NONE:    state_next = ST_IDLE;
                    endcase
                end
            end

            ST_HIT_SCAN:
            begin
                if (valid_reg[idx_reg] && u_out.tag_eq)
                begin
                    state_next = ST_HIT_ACT;
                end
                else if (idx_end)
                begin
                    idx_next   = '0;
                    state_next = ST_AGE_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + sidx_t'(1);
                end
            end

            ST_HIT_ACT:
            begin
                ov_next    = 1'b1;
                ok_next    = RES_STATUS;
                os_next    = 6'(idx_reg);
                osec_next  = sec_reg;
                olast_next = 1'b1;
                state_next = ST_IDLE;
                if (plain_read && mode_reg[idx_reg] == 2'd1)
                begin
                    hcnt_next[idx_reg] = sat_inc(hcnt_reg[idx_reg]);
                    ucnt_next[idx_reg] = sat_inc(ucnt_reg[idx_reg]);
                    ost_next           = STS_HIT;
                end
                else if (hcnt_reg[idx_reg] == '0)
                begin
                    mode_next[idx_reg]  = mb_reg;
                    dirty_next[idx_reg] = dirty_reg[idx_reg] | mb_reg[1];
                    hcnt_next[idx_reg]  = cnt_t'(1);
                    ucnt_next[idx_reg]  = sat_inc(ucnt_reg[idx_reg]);
                    ost_next            = STS_HIT;
                end
                else
                begin
                    ost_next = STS_BUSY;
                end
            end

            ST_AGE_SCAN:
            begin
                if (hcnt_reg[idx_reg] == '0)
                begin
                    age_next[idx_reg] = u_out.age_inc;
                    if (!found_reg || u_out.better)
                    begin
                        found_next = 1'b1;
                        lru_next   = idx_reg;
                        bage_next  = u_out.age_inc;
                        buse_next  = ucnt_reg[idx_reg];
                    end
                end
                if (idx_end)
                begin
                    state_next = ST_MISS_WB;
                end
                else
                begin
                    idx_next = idx_reg + sidx_t'(1);
                end
            end

            ST_MISS_WB:
            begin
                idx_next   = lru_reg;
                state_next = ST_MISS_FILL;
                if (!found_reg)
                begin
                    ov_next    = 1'b1;
                    osec_next  = sec_reg;
                    ost_next   = STS_NO_FREE;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (dirty_reg[lru_reg])
                begin
                    ov_next   = 1'b1;
                    os_next   = 6'(lru_reg);
                    if (!in_bounds(tag_reg[lru_reg], total_reg))
                    begin
                        osec_next  = sec_reg;
                        ost_next   = STS_OOB;
                        olast_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ok_next   = RES_WRITEBACK;
                        osec_next = tag_reg[lru_reg];
                    end
                end
            end

            ST_MISS_FILL:
            begin
                ov_next    = 1'b1;
                os_next    = 6'(idx_reg);
                osec_next  = sec_reg;
                state_next = ST_MISS_DONE;
                if (nf_reg)
                begin
                    ok_next = RES_ZERO_FILL;
                end
                else if (!in_bounds(sec_reg, total_reg))
                begin
                    ost_next   = STS_OOB;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ok_next = RES_FETCH;
                end
            end

            ST_MISS_DONE:
            begin
                mode_next[idx_reg]  = mb_reg;
                ucnt_next[idx_reg]  = cnt_t'(1);
                age_next[idx_reg]   = '0;
                hcnt_next[idx_reg]  = cnt_t'(1);
                tag_next[idx_reg]   = sec_reg;
                dirty_next[idx_reg] = mb_reg[1];
                valid_next[idx_reg] = 1'b1;
                ov_next    = 1'b1;
                os_next    = 6'(idx_reg);
                osec_next  = sec_reg;
                ost_next   = STS_FILLED;
                olast_next = 1'b1;
                state_next = ST_IDLE;
            end

            ST_RELEASE:
            begin
                ov_next    = 1'b1;
                os_next    = rslot_reg;
                olast_next = 1'b1;
                state_next = ST_IDLE;
                if (rslot_reg >= 6'(SLOTS) || hcnt_reg[idx_reg] == '0)
                begin
                    ost_next = STS_NOT_HELD;
                end
                else
                begin
                    hcnt_next[idx_reg] = hcnt_reg[idx_reg] - cnt_t'(1);
                    ost_next           = STS_RELEASED;
                end
            end

            ST_FLUSH_SCAN:
            begin
                if (hcnt_reg[idx_reg] == '0 && dirty_reg[idx_reg])
                begin
                    if (in_bounds(tag_reg[idx_reg], total_reg))
                    begin
                        ov_next   = 1'b1;
                        ok_next   = RES_WRITEBACK;
                        os_next   = 6'(idx_reg);
                        osec_next = tag_reg[idx_reg];
                    end
                    mode_next[idx_reg]  = 2'd1;
                    dirty_next[idx_reg] = 1'b0;
                    for (int x = 0; x < SLOTS; x++)
                    begin
                        if (sidx_t'(x) != idx_reg && tag_reg[x] == tag_reg[idx_reg] &&
                            mode_reg[x] == 2'd1)
                        begin
                            dirty_next[x] = 1'b1;
                        end
                    end
                end
                if (idx_end)
                begin
                    state_next = ST_FLUSH_END;
                end
                else
                begin
                    idx_next = idx_reg + sidx_t'(1);
                end
            end

            ST_FLUSH_END:
            begin
                ov_next    = 1'b1;
                ost_next   = STS_FLUSHED;
                olast_next = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SBC_ASSERT_IMP(a_last_is_status, res_valid && last, res_kind == RES_STATUS, "last item not a status")
    `SBC_ASSERT_IMP(a_cmd_status_zero, res_valid && res_kind != RES_STATUS, status == STS_HIT && !last, "command item carries status")
    `SBC_ASSERT_NXT(a_gap_after_last, res_valid && last, !res_valid, "item right after last")
    `SBC_ASSERT_NXT(a_start_busy, start && !busy && kind != KIND_NONE, busy, "request accepted but not busy")

endmodule

### sim/sbc_checker.sv
module sbc_checker
    import sbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] sector,
    input  logic [1:0]  mode_bits,
    input  logic        no_fill,
    input  logic [5:0]  slot,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        res_valid,
    input  logic [1:0]  res_kind,
    input  logic [5:0]  res_slot,
    input  logic [31:0] res_sector,
    input  logic [2:0]  status,
    input  logic        last,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        res_kind_t   rk;
        logic [5:0]  rslot;
        logic [31:0] rsector;
        status_t     rsts;
        logic        rlast;
    } cache_res_t;

    cache_res_t   awaited[$];
    logic [31:0]  dev_size;
    logic [31:0]  tags [SLOTS];
    logic         valid [SLOTS];
    logic [1:0]   mode [SLOTS];
    logic         dirty [SLOTS];
    cnt_t         handles [SLOTS];
    cnt_t         ages [SLOTS];
    cnt_t         uses [SLOTS];

    assign pending = awaited.size();

    function automatic cnt_t bump(cnt_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic fits(logic [31:0] s);
        return (dev_size == 0) || ({1'b0, s} + 33'd1 <= {1'b0, dev_size});
    endfunction

    task automatic push(res_kind_t k, int unsigned s, logic [31:0] sec, status_t st,
                        logic l);
        awaited.push_back('{k, 6'(s), sec, st, l});
    endtask

    task automatic predict_get(logic [31:0] sec, logic [1:0] m, logic nf);
        int hit;
        int lru;
        logic plain;
        hit = -1;
        lru = -1;
        plain = (m == 2'd1) && !nf;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && valid[i] && tags[i] == sec)
                hit = i;
        if (hit >= 0) begin
            if (plain && mode[hit] == 2'd1) begin
                handles[hit] = bump(handles[hit]);
                uses[hit] = bump(uses[hit]);
                push(RES_STATUS, hit, sec, STS_HIT, 1'b1);
            end else if (handles[hit] == 0) begin
                mode[hit] = m;
                if (m[1])
                    dirty[hit] = 1'b1;
                handles[hit] = 1;
                uses[hit] = bump(uses[hit]);
                push(RES_STATUS, hit, sec, STS_HIT, 1'b1);
            end else
                push(RES_STATUS, hit, sec, STS_BUSY, 1'b1);
            return;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (handles[i] != 0)
                continue;
            ages[i] = bump(ages[i]);
            if (lru < 0)
                lru = i;
            if (ages[i] > ages[lru] || (ages[i] == ages[lru] && uses[i] > uses[lru]))
                lru = i;
        end
        if (lru < 0) begin
            push(RES_STATUS, 0, sec, STS_NO_FREE, 1'b1);
            return;
        end
        if (dirty[lru]) begin
            if (!fits(tags[lru])) begin
                push(RES_STATUS, lru, sec, STS_OOB, 1'b1);
                return;
            end
            push(RES_WRITEBACK, lru, tags[lru], STS_HIT, 1'b0);
        end
        if (nf)
            push(RES_ZERO_FILL, lru, sec, STS_HIT, 1'b0);
        else if (!fits(sec)) begin
            push(RES_STATUS, lru, sec, STS_OOB, 1'b1);
            return;
        end else
            push(RES_FETCH, lru, sec, STS_HIT, 1'b0);
        mode[lru] = m;
        uses[lru] = 1;
        ages[lru] = 0;
        handles[lru] = 1;
        tags[lru] = sec;
        dirty[lru] = m[1];
        valid[lru] = 1'b1;
        push(RES_STATUS, lru, sec, STS_FILLED, 1'b1);
    endtask

    task automatic predict_flush();
        for (int i = 0; i < SLOTS; i++) begin
            if (handles[i] != 0 || !dirty[i])
                continue;
            if (fits(tags[i]))
                push(RES_WRITEBACK, i, tags[i], STS_HIT, 1'b0);
            mode[i] = 2'd1;
            dirty[i] = 1'b0;
            for (int x = 0; x < SLOTS; x++)
                if (x != i && tags[x] == tags[i] && mode[x] == 2'd1)
                    dirty[x] = 1'b1;
        end
        push(RES_STATUS, 0, 32'd0, STS_FLUSHED, 1'b1);
    endtask

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        cache_res_t exp_r;
        if (!rst_n) begin
            errors = 0;
            dev_size = 0;
            awaited.delete();
            for (int i = 0; i < SLOTS; i++) begin
                tags[i] = 0; valid[i] = 0; mode[i] = 0; dirty[i] = 0;
                handles[i] = 0; ages[i] = 0; uses[i] = 0;
            end
        end else begin
            if (res_valid) begin
                if (awaited.size() == 0)
                    report($sformatf("unexpected result kind %0d slot %0d", res_kind,
                                     res_slot));
                else begin
                    exp_r = awaited.pop_front();
                    if (res_kind !== exp_r.rk)
                        report($sformatf("res_kind %0d, want %0d", res_kind, exp_r.rk));
                    if (res_slot !== exp_r.rslot)
                        report($sformatf("res_slot %0d, want %0d", res_slot, exp_r.rslot));
                    if (res_sector !== exp_r.rsector)
                        report($sformatf("res_sector %h, want %h", res_sector,
                                         exp_r.rsector));
                    if (status !== exp_r.rsts)
                        report($sformatf("status %0d, want %0d", status, exp_r.rsts));
                    if (last !== exp_r.rlast)
                        report($sformatf("last %0d, want %0d", last, exp_r.rlast));
                end
            end
            if (cfg_valid && cfg_ready)
                dev_size = cfg_data;
            if (start && !busy) begin
                case (kind_t'(kind))
                    KIND_GET: predict_get(sector, mode_bits, no_fill);
                    KIND_RELEASE: begin
                        if (slot >= SLOTS || handles[slot] == 0)
                            push(RES_STATUS, slot, 32'd0, STS_NOT_HELD, 1'b1);
                        else begin
                            handles[slot] = handles[slot] - 1'b1;
                            push(RES_STATUS, slot, 32'd0, STS_RELEASED, 1'b1);
                        end
                    end
                    KIND_FLUSH: predict_flush();
                    default: ;
                endcase
            end
        end
    end

endmodule

### sim/tb.sv
module tb;
    import sbc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [31:0] sector;
    logic [1:0]  mode_bits;
    logic        no_fill;
    logic [5:0]  slot;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [5:0]  res_slot;
    logic [31:0] res_sector;
    logic [2:0]  status;
    logic        last;
    int          errors;
    int          pending;
    int          cycles;
    logic [31:0] pool [8];

    sector_buffer_cache_policy i_dut (.*);

    sbc_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic issue(kind_t k, logic [31:0] s, logic [1:0] m, logic nf, logic [5:0] sl);
        repeat ($urandom_range(0, 19) * ($urandom_range(0, 3) != 0)) @(posedge clk);
        start <= 1'b1;
        kind <= k;
        sector <= s;
        mode_bits <= m;
        no_fill <= nf;
        slot <= sl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
    endtask

    task automatic settle();
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_size(logic [31:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            issue(KIND_GET,
                  ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 7)],
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 3) == 0), 6'd0);
        else if (r < 90)
            issue(KIND_RELEASE, $urandom(), 2'($urandom()),
                  1'($urandom()), ($urandom_range(0, 9) == 0) ? 6'($urandom()) :
                  6'($urandom_range(0, SLOTS - 1)));
        else if (r < 98)
            issue(KIND_FLUSH, $urandom(), 2'($urandom()), 1'($urandom()), 6'($urandom()));
        else
            issue(KIND_NONE, $urandom(), 2'($urandom()), 1'($urandom()), 6'($urandom()));
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        kind = 0;
        sector = 0;
        mode_bits = 0;
        no_fill = 0;
        slot = 0;
        cfg_valid = 0;
        cfg_data = 0;
        for (int i = 0; i < 8; i++)
            pool[i] = (i < 4) ? 32'(i) : $urandom_range(0, 300);
        pool[7] = 32'hFFFF_FFFF;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sharing, busy, claim, no free slot, bounds, release, flush
        issue(KIND_GET, 32'd5, 2'd1, 1'b0, 6'd0);
        issue(KIND_GET, 32'd5, 2'd1, 1'b0, 6'd0);
        issue(KIND_GET, 32'd5, 2'd2, 1'b0, 6'd0);
        issue(KIND_GET, 32'hFFFF_FFFF, 2'd3, 1'b1, 6'd0);
        issue(KIND_RELEASE, 32'd0, 2'd0, 1'b0, 6'd63);
        issue(KIND_RELEASE, 32'd0, 2'd0, 1'b0, 6'd1);
        issue(KIND_RELEASE, 32'd0, 2'd0, 1'b0, 6'd1);
        issue(KIND_FLUSH, 32'd0, 2'd0, 1'b0, 6'd0);
        for (int i = 0; i < SLOTS; i++)
            issue(KIND_GET, 32'(100 + i), 2'd2, 1'b1, 6'd0);
        issue(KIND_GET, 32'd999, 2'd1, 1'b0, 6'd0);
        issue(KIND_NONE, 32'd0, 2'd0, 1'b0, 6'd0);
        for (int i = 0; i < SLOTS; i++)
            issue(KIND_RELEASE, 32'd0, 2'd0, 1'b0, 6'(i));
        set_size(32'd50);
        issue(KIND_GET, 32'd60, 2'd1, 1'b0, 6'd0);
        issue(KIND_GET, 32'd49, 2'd0, 1'b0, 6'd0);
        issue(KIND_FLUSH, 32'd0, 2'd0, 1'b0, 6'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_size(32'd0);
                1: set_size(32'd4);
                2: set_size(32'hFFFF_FFFF);
                default: set_size($urandom_range(1, 300));
            endcase
            for (int n = 0; n < 85; n++)
                random_item();
        end
        settle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sector_buffer_cache_policy.f
+incdir+hdl
hdl/sbc_pkg.sv
hdl/sbc_unit.sv
hdl/sector_buffer_cache_policy.sv
sim/sbc_checker.sv
sim/tb.sv
